>>> hw/rtl/tapm_pkg.sv
// ----------------------------------------------------------------------------
// tapm_pkg
// Shared widths, codes, types and control bundle of the three-axis PID
// attitude controller with motor mixing.
// ----------------------------------------------------------------------------
package tapm_pkg;

  localparam int DataW = 16;
  localparam int ErrW  = 17;
  localparam int IntW  = 32;
  localparam int MulAW = 17;
  localparam int MulBW = 33;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 42;
  localparam int MixW  = 34;
  localparam int GainW = 48;
  localparam int InW   = 152;
  localparam int OutW  = 64;
  localparam int IdxW  = 2;

  localparam logic [1:0] AX_ROLL  = 2'd0;
  localparam logic [1:0] AX_PITCH = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;

  localparam logic [IdxW-1:0] REG_GAINS_ROLL  = 2'd0;
  localparam logic [IdxW-1:0] REG_GAINS_PITCH = 2'd1;
  localparam logic [IdxW-1:0] REG_GAINS_YAW   = 2'd2;

  localparam logic [1:0] MIX_ONE   = 2'd0;
  localparam logic [1:0] MIX_TWO   = 2'd1;
  localparam logic [1:0] MIX_THREE = 2'd2;
  localparam logic [1:0] MIX_FOUR  = 2'd3;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_I,
    ACC_SUB_D,
    ACC_MIX
  } acc_op_t;

  typedef enum logic [1:0] {
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC_D,
    ST_SAT,
    ST_MIX,
    ST_MIX_WR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       in_ready;
    logic       err_we;
    logic       mul_en;
    mul_sel_t   mul_sel;
    acc_op_t    acc_op;
    logic       sum_we;
    logic       mix_we;
    logic       out_load;
    logic [1:0] axis;
    logic [1:0] mix_sel;
  } ctrl_t;

endpackage

>>> hw/rtl/tapm_mac.sv
// ----------------------------------------------------------------------------
// tapm_mac
// Shared multiply-accumulate unit: one registered gain-by-operand product,
// an accumulator, and the saturating readouts for axis sums and mix values.
// ----------------------------------------------------------------------------
module tapm_mac import tapm_pkg::*; (
  input  logic                    clk,
  input  ctrl_t                   ctrl,
  input  logic [DataW-1:0]        gain,
  input  logic signed [MulBW-1:0] opb,
  input  logic signed [MixW-1:0]  mix_x,
  input  logic signed [MixW-1:0]  mix_y,
  output logic signed [IntW-1:0]  sum_sat,
  output logic signed [DataW-1:0] mix_sat
);

  localparam logic signed [AccW-1:0] SumMax = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] SumMin = AccW'(-64'sd2147483648);
  localparam logic signed [AccW-1:0] MixMax = AccW'(64'sd32767);
  localparam logic signed [AccW-1:0] MixMin = AccW'(-64'sd32768);

  logic signed [MulAW-1:0] mul_a;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] prod_shr;
  logic signed [ProdW-1:0] prod_shl;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  quot;
  logic signed [AccW-1:0]  quot_trunc;

  assign mul_a    = $signed({1'b0, gain});
  assign prod_shr = prod >>> 8;
  assign prod_shl = prod <<< 4;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * opb;
    end
    case (ctrl.acc_op)
      ACC_LOAD:  acc <= $signed(prod[AccW-1:0]);
      ACC_ADD_I: acc <= acc + $signed(prod_shr[AccW-1:0]);
      ACC_SUB_D: acc <= acc - $signed(prod_shl[AccW-1:0]);
      ACC_MIX:   acc <= AccW'(mix_x) + AccW'(mix_y);
      default:   acc <= acc;
    endcase
  end

  always_comb begin
    if (acc > SumMax) begin
      sum_sat = IntW'(SumMax);
    end else if (acc < SumMin) begin
      sum_sat = IntW'(SumMin);
    end else begin
      sum_sat = acc[IntW-1:0];
    end
  end

  // Integer part rounds toward zero, so negative values with a fraction step up.
  assign quot = acc >>> 16;
  assign quot_trunc = (acc[AccW-1] && (acc[15:0] != 16'd0)) ? quot + AccW'(1) : quot;

  always_comb begin
    if (quot_trunc > MixMax) begin
      mix_sat = DataW'(MixMax);
    end else if (quot_trunc < MixMin) begin
      mix_sat = DataW'(MixMin);
    end else begin
      mix_sat = quot_trunc[DataW-1:0];
    end
  end

endmodule

>>> hw/rtl/tapm_ctrl.sv
// ----------------------------------------------------------------------------
// tapm_ctrl
// Sequencer that steps the shared multiply-accumulate unit through the three
// axis updates of an enabled beat and the four mix values of every beat.
// ----------------------------------------------------------------------------
module tapm_ctrl import tapm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  enable,
  input  logic  out_busy,
  output ctrl_t ctrl
);

  state_t     state;
  state_t     state_next;
  logic [1:0] axis;
  logic [1:0] mix_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      axis    <= AX_ROLL;
      mix_sel <= MIX_ONE;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        axis    <= AX_ROLL;
        mix_sel <= MIX_ONE;
      end
      if (state == ST_SAT) begin
        axis <= axis + 2'd1;
      end
      if (state == ST_MIX_WR) begin
        mix_sel <= mix_sel + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = enable ? ST_ERR : ST_MIX;
        end
      end
      ST_ERR:   state_next = ST_MUL_P;
      ST_MUL_P: state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_ACC_D;
      ST_ACC_D: state_next = ST_SAT;
      ST_SAT:   state_next = (axis == AX_YAW) ? ST_MIX : ST_ERR;
      ST_MIX:   state_next = ST_MIX_WR;
      ST_MIX_WR: begin
        state_next = (mix_sel == MIX_FOUR) ? ST_OUT : ST_MIX;
      end
      ST_OUT: begin
        if (!out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.mul_sel  = MUL_P;
    ctrl.acc_op   = ACC_HOLD;
    ctrl.axis     = axis;
    ctrl.mix_sel  = mix_sel;
    case (state)
      ST_IDLE:  ctrl.in_ready = 1'b1;
      ST_ERR:   ctrl.err_we = 1'b1;
      ST_MUL_P: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_P;
      end
      ST_MUL_I: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_I;
        ctrl.acc_op  = ACC_LOAD;
      end
      ST_MUL_D: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_D;
        ctrl.acc_op  = ACC_ADD_I;
      end
      ST_ACC_D:  ctrl.acc_op = ACC_SUB_D;
      ST_SAT:    ctrl.sum_we = 1'b1;
      ST_MIX:    ctrl.acc_op = ACC_MIX;
      ST_MIX_WR: ctrl.mix_we = 1'b1;
      ST_OUT:    ctrl.out_load = !out_busy;
      default:   ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

>>> hw/rtl/three_axis_pid_motor_mixer.sv
// ----------------------------------------------------------------------------
// three_axis_pid_motor_mixer
// Three-axis PID attitude controller with four-motor mixing.
//
// The slave stream takes one beat per attitude sample: the enable flag,
// desired and measured angles for three axes and three gyro rates. The
// master stream returns one beat per sample with the four saturated motor
// mix values. Gains are to be written through the plain configuration port
// only while the block is idle; the block itself does not enforce this.
// Indexes 0, 1 and 2 select the roll, pitch and yaw gain words, and any
// other index is ignored. One multiplier and one accumulator are shared
// under a sequencer: each axis steps through an error state, the P, I and
// D multiply states, a D accumulate state and a saturate state, and each
// mix value through a sum and a write state; a disabled beat skips the axes.
// s_axis_tready is high only while idle. A result that the receiver has not
// yet taken waits in the output register; the next beat is then accepted and
// processed, and its result is held back until the register frees up.
// Reset clears the gains, integrators, held sums and the output valid flag.
// ----------------------------------------------------------------------------
module three_axis_pid_motor_mixer import tapm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IdxW-1:0]  cfg_index,
  input  logic [GainW-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // control_enable, desired_theta, desired_phi, desired_psi, actual_theta,
  // actual_phi, actual_psi, rate_roll, rate_pitch, rate_yaw, zero pad
  input  logic [InW-1:0]   s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // motor_one_mix, motor_two_mix, motor_three_mix, motor_four_mix
  output logic [OutW-1:0]  m_axis_tdata
);

  ctrl_t                   ctrl;
  logic                    start;
  logic                    out_busy;
  logic [InW-1:0]          in_r;
  logic [GainW-1:0]        gains [3];
  logic signed [IntW-1:0]  integ [3];
  logic signed [IntW-1:0]  sums [3];
  logic signed [ErrW-1:0]  err;
  logic signed [ErrW-1:0]  err_next;
  logic signed [IntW:0]    integ_sum;
  logic signed [IntW-1:0]  integ_next;
  logic signed [DataW-1:0] des;
  logic signed [DataW-1:0] act;
  logic signed [DataW-1:0] rate;
  logic [GainW-1:0]        gain_word;
  logic [DataW-1:0]        gain;
  logic signed [MulBW-1:0] opb;
  logic signed [MixW-1:0]  mix_x;
  logic signed [MixW-1:0]  mix_y;
  logic signed [IntW-1:0]  sum_sat;
  logic signed [DataW-1:0] mix_sat;
  logic [DataW-1:0]        mix_r [4];

  assign start         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = ctrl.in_ready;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;

  tapm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .enable   (s_axis_tdata[0]),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gains[0] <= '0;
      gains[1] <= '0;
      gains[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAINS_ROLL:  gains[0] <= cfg_data;
        REG_GAINS_PITCH: gains[1] <= cfg_data;
        REG_GAINS_YAW:   gains[2] <= cfg_data;
        default:         gains[0] <= gains[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= s_axis_tdata;
    end
  end

  always_comb begin
    case (ctrl.axis)
      AX_ROLL: begin
        des  = $signed(in_r[32:17]);
        act  = $signed(in_r[80:65]);
        rate = $signed(in_r[112:97]);
      end
      AX_PITCH: begin
        des  = $signed(in_r[16:1]);
        act  = $signed(in_r[64:49]);
        rate = $signed(in_r[128:113]);
      end
      default: begin
        des  = $signed(in_r[48:33]);
        act  = $signed(in_r[96:81]);
        rate = $signed(in_r[144:129]);
      end
    endcase
  end

  assign err_next  = ErrW'(des) - ErrW'(act);
  assign integ_sum = (IntW + 1)'(integ[ctrl.axis]) + (IntW + 1)'(err_next);

  always_comb begin
    if (integ_sum[IntW] != integ_sum[IntW-1]) begin
      integ_next = integ_sum[IntW] ? {1'b1, {(IntW - 1){1'b0}}} : {1'b0, {(IntW - 1){1'b1}}};
    end else begin
      integ_next = integ_sum[IntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ[0] <= '0;
      integ[1] <= '0;
      integ[2] <= '0;
      sums[0]  <= '0;
      sums[1]  <= '0;
      sums[2]  <= '0;
    end else begin
      if (ctrl.err_we) begin
        integ[ctrl.axis] <= integ_next;
      end
      if (ctrl.sum_we) begin
        sums[ctrl.axis] <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.err_we) begin
      err <= err_next;
    end
  end

  always_comb begin
    case (ctrl.axis)
      AX_ROLL:  gain_word = gains[0];
      AX_PITCH: gain_word = gains[1];
      default:  gain_word = gains[2];
    endcase
  end

  always_comb begin
    case (ctrl.mul_sel)
      MUL_P: begin
        gain = gain_word[47:32];
        opb  = MulBW'(err);
      end
      MUL_I: begin
        gain = gain_word[31:16];
        opb  = MulBW'(integ[ctrl.axis]);
      end
      default: begin
        gain = gain_word[15:0];
        opb  = MulBW'(rate);
      end
    endcase
  end

  always_comb begin
    case (ctrl.mix_sel)
      MIX_ONE: begin
        mix_x = MixW'(sums[AX_ROLL]);
        mix_y = MixW'(sums[AX_YAW]);
      end
      MIX_TWO: begin
        mix_x = MixW'(sums[AX_PITCH]);
        mix_y = -MixW'(sums[AX_YAW]);
      end
      MIX_THREE: begin
        mix_x = -MixW'(sums[AX_ROLL]);
        mix_y = MixW'(sums[AX_YAW]);
      end
      default: begin
        mix_x = -MixW'(sums[AX_PITCH]);
        mix_y = -MixW'(sums[AX_YAW]);
      end
    endcase
  end

  tapm_mac u_mac (
    .clk     (clk),
    .ctrl    (ctrl),
    .gain    (gain),
    .opb     (opb),
    .mix_x   (mix_x),
    .mix_y   (mix_y),
    .sum_sat (sum_sat),
    .mix_sat (mix_sat)
  );

  always_ff @(posedge clk) begin
    if (ctrl.mix_we) begin
      mix_r[ctrl.mix_sel] <= mix_sat;
    end
    if (ctrl.out_load) begin
      m_axis_tdata <= {mix_r[3], mix_r[2], mix_r[1], mix_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule
